/* rtl/arp_cache_responder_defines.svh */
// Assertion macros for the ARP cache and responder.
`ifndef ARP_CACHE_RESPONDER_DEFINES_SVH
`define ARP_CACHE_RESPONDER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition that holds at every clock edge out of reset.
`define ARPC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("arp_cache_responder: invariant violated");

// Implication checked in the same cycle.
`define ARPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("arp_cache_responder: implication violated");

`else

`define ARPC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ARPC_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/arpc_pkg.sv */
// Shared types, codes and constants of the ARP cache and responder.
package arpc_pkg;

	localparam int ARPC_TABLE_ENTRIES = 16;
	localparam int ARPC_CMDQ_DEPTH    = 2;

	localparam int IP_W  = 32;
	localparam int MAC_W = 48;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IFACE_UP = 2'd2;

	// item actions
	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_HEADER = 2'd1;
	localparam logic [1:0] ACT_SEND   = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_MISS        = 3'd1;
	localparam logic [2:0] ST_SHORT       = 3'd2;
	localparam logic [2:0] ST_UNSUPPORTED = 3'd3;
	localparam logic [2:0] ST_DOWN        = 3'd4;

	// header checks
	localparam logic [10:0] MIN_HEADER_LEN = 11'd28;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_LEN_MAC     = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IP   = 8'd4;
	localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

	// opcode of a frame to send
	localparam logic [1:0] SEND_OP_NONE    = 2'd0;
	localparam logic [1:0] SEND_OP_REQUEST = 2'd1;
	localparam logic [1:0] SEND_OP_REPLY   = 2'd2;

	localparam logic [MAC_W-1:0] MAC_BCAST = {MAC_W{1'b1}};

	// what the back end has to do with a command
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_FIXED  = 2'd0;	// result fully known up front
	localparam kind_t KIND_LOOKUP = 2'd1;
	localparam kind_t KIND_LEARN  = 2'd2;

	typedef struct packed {
		logic [2:0]       status;
		logic [MAC_W-1:0] found_mac;
		logic             send;
		logic [1:0]       send_opcode;
		logic [MAC_W-1:0] send_dest_mac;
		logic [MAC_W-1:0] send_target_mac;
		logic [IP_W-1:0]  send_target_ip;
	} res_t;

	typedef struct packed {
		kind_t            kind;
		logic [IP_W-1:0]  key_ip;
		logic [MAC_W-1:0] mac;
		res_t             res;
	} cmd_t;

endpackage

/* rtl/arpc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module arpc_ram
	import arpc_pkg::*;
#(
	parameter int WIDTH = MAC_W,
	parameter int DEPTH = ARPC_TABLE_ENTRIES
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/arpc_front.sv */
// Front end: decodes and checks an item and builds a back-end command.
module arpc_front
	import arpc_pkg::*;
(
	input  logic [1:0]       action,
	input  logic [10:0]      header_length,
	input  logic [15:0]      opcode,
	input  logic [15:0]      protocol,
	input  logic [7:0]       hw_len,
	input  logic [7:0]       proto_len,
	input  logic [MAC_W-1:0] sender_mac,
	input  logic [IP_W-1:0]  sender_ip,
	input  logic [IP_W-1:0]  query_ip,
	input  logic [IP_W-1:0]  own_ip,
	input  logic             iface_up,
	output cmd_t             cmd
);

	logic hdr_bad;

	assign hdr_bad = (protocol != PROTO_IPV4) || (hw_len != HW_LEN_MAC) ||
		(proto_len != PROTO_LEN_IP);

	always_comb begin
		cmd        = '0;
		cmd.kind   = KIND_FIXED;
		cmd.key_ip = query_ip;
		cmd.mac    = sender_mac;
		unique case (action)
			ACT_LOOKUP: begin
				cmd.kind = KIND_LOOKUP;
			end
			ACT_HEADER: begin
				if (header_length < MIN_HEADER_LEN) begin
					cmd.res.status = ST_SHORT;
				end else if (hdr_bad) begin
					cmd.res.status = ST_UNSUPPORTED;
				end else begin
					cmd.kind   = KIND_LEARN;
					cmd.key_ip = sender_ip;
					// request aimed at us: reply goes out even while down
					if (opcode == ARP_OP_REQUEST && query_ip == own_ip) begin
						cmd.res.send            = 1'b1;
						cmd.res.send_opcode     = SEND_OP_REPLY;
						cmd.res.send_dest_mac   = sender_mac;
						cmd.res.send_target_mac = sender_mac;
						cmd.res.send_target_ip  = sender_ip;
					end
				end
			end
			ACT_SEND: begin
				if (!iface_up) begin
					cmd.res.status = ST_DOWN;
				end else begin
					cmd.res.send           = 1'b1;
					cmd.res.send_opcode    = SEND_OP_REQUEST;
					cmd.res.send_dest_mac  = MAC_BCAST;
					cmd.res.send_target_ip = query_ip;
				end
			end
			default: begin
				cmd.res.status = ST_UNSUPPORTED;
			end
		endcase
	end

endmodule

/* rtl/arpc_cmd_fifo.sv */
// Short command queue between the front and back ends.
module arpc_cmd_fifo
	import arpc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	localparam int DEPTH = ARPC_CMDQ_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/arpc_back.sv */
// Back end: table match, first-free search, learning and the result register.
module arpc_back
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  cmd_t                     cmd,
	output logic                     cmd_take,
	output res_t                     res,
	output logic                     res_valid,
	input  logic                     res_pop,
	output logic [TABLE_ENTRIES-1:0] valid_vec
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	localparam logic [1:0] BK_IDLE    = 2'd0;
	localparam logic [1:0] BK_MATCH   = 2'd1;
	localparam logic [1:0] BK_RESOLVE = 2'd2;
	localparam logic [1:0] BK_FINISH  = 2'd3;

	logic [1:0]               state_q;
	cmd_t                     cmd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IP_W-1:0]          ip_q [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] match_q;
	logic [TABLE_ENTRIES-1:0] free_q;
	logic                     hit_q;
	logic                     any_free_q;
	logic [IDX_W-1:0]         hit_idx_q;
	logic [IDX_W-1:0]         free_idx_q;
	res_t                     res_q;
	logic                     res_valid_q;

	logic [TABLE_ENTRIES-1:0] match_vec;
	logic [TABLE_ENTRIES-1:0] match_low;
	logic [TABLE_ENTRIES-1:0] free_low;
	logic [IDX_W-1:0]         hit_idx;
	logic [IDX_W-1:0]         free_idx;
	logic                     finish;
	logic                     learn_we;
	logic                     learn_new;
	logic [IDX_W-1:0]         learn_idx;
	logic [MAC_W-1:0]         ram_rdata;
	res_t                     res_next;

	assign cmd_take  = (state_q == BK_IDLE) && cmd_valid;
	assign finish    = (state_q == BK_FINISH) && (!res_valid_q || res_pop);
	assign res       = res_q;
	assign res_valid = res_valid_q;
	assign valid_vec = valid_q;

	// parallel compare against every entry
	always_comb begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			match_vec[i] = valid_q[i] && (ip_q[i] == cmd_q.key_ip);
		end
	end

	// lowest set bit, then one-hot to index
	assign match_low = match_q & (~match_q + 1'b1);
	assign free_low  = free_q & (~free_q + 1'b1);

	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		for (int b = 0; b < IDX_W; b++) begin
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (((i >> b) & 1) == 1) begin
					hit_idx[b]  = hit_idx[b] | match_low[i];
					free_idx[b] = free_idx[b] | free_low[i];
				end
			end
		end
	end

	assign learn_we  = finish && (cmd_q.kind == KIND_LEARN) && (hit_q || any_free_q);
	assign learn_new = !hit_q;
	assign learn_idx = hit_q ? hit_idx_q : free_idx_q;

	arpc_ram #(
		.WIDTH (MAC_W),
		.DEPTH (TABLE_ENTRIES)
	) u_mac_ram (
		.clk   (clk),
		.we    (learn_we),
		.waddr (learn_idx),
		.wdata (cmd_q.mac),
		.re    (state_q == BK_RESOLVE),
		.raddr (hit_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		res_next = cmd_q.res;
		if (cmd_q.kind == KIND_LOOKUP) begin
			res_next           = '0;
			res_next.status    = hit_q ? ST_OK : ST_MISS;
			res_next.found_mac = hit_q ? ram_rdata : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BK_IDLE: begin
					if (cmd_valid) begin
						state_q <= (cmd.kind == KIND_FIXED) ? BK_FINISH : BK_MATCH;
					end
				end
				BK_MATCH: begin
					state_q <= BK_RESOLVE;
				end
				BK_RESOLVE: begin
					state_q <= BK_FINISH;
				end
				BK_FINISH: begin
					if (finish) begin
						state_q <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (learn_we && learn_new) begin
				valid_q[learn_idx] <= 1'b1;
			end
			if (finish) begin
				res_valid_q <= 1'b1;
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (state_q == BK_MATCH) begin
			match_q <= match_vec;
			free_q  <= ~valid_q;
		end
		if (state_q == BK_RESOLVE) begin
			hit_q      <= |match_q;
			any_free_q <= |free_q;
			hit_idx_q  <= hit_idx;
			free_idx_q <= free_idx;
		end
		if (learn_we && learn_new) begin
			ip_q[learn_idx] <= cmd_q.key_ip;
		end
		if (finish) begin
			res_q <= res_next;
		end
	end

endmodule

/* rtl/arp_cache_responder.sv */
// ARP cache and responder top level.
//
//   channel   direction  handshake              payload
//   item      in         push / full            action .. query_ip
//   result    out        pop / empty            status .. send_target_ip
//   config    in         cfg_we (no stall)      cfg_index, cfg_wdata
//
// A lookup or a valid header goes through the back-end steps match,
// resolve and finish after idle picks the command out of the queue;
// other items go from idle to finish. The back end handles one item at a
// time; the front queue holds 2 decoded items, the result register 1 more.
// Reset clears the table valid bits, the queue and the result register; no
// clearing pass is needed. A stalled result holds the back end in its
// finish step, and the queue fills behind it.
`include "arp_cache_responder_defines.svh"

module arp_cache_responder
	import arpc_pkg::*;
#(
	parameter int TABLE_ENTRIES = ARPC_TABLE_ENTRIES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// items
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            action,
	input  logic [10:0]           header_length,
	input  logic [15:0]           opcode,
	input  logic [15:0]           protocol,
	input  logic [7:0]            hw_len,
	input  logic [7:0]            proto_len,
	input  logic [MAC_W-1:0]      sender_mac,
	input  logic [IP_W-1:0]       sender_ip,
	input  logic [IP_W-1:0]       query_ip,
	// results
	output logic                  empty,
	input  logic                  pop,
	output logic [2:0]            status,
	output logic [MAC_W-1:0]      found_mac,
	output logic                  send,
	output logic [1:0]            send_opcode,
	output logic [MAC_W-1:0]      send_dest_mac,
	output logic [MAC_W-1:0]      send_target_mac,
	output logic [IP_W-1:0]       send_target_ip
);

	// own MAC is the source address of every frame; the transmit path
	// fills it in, so writes to its index are accepted and dropped here
	logic [IP_W-1:0]          own_ip_q;
	logic                     iface_up_q;

	cmd_t                     front_cmd;
	cmd_t                     q_cmd;
	logic                     q_empty;
	logic                     q_take;
	res_t                     res;
	logic                     res_valid;
	logic [TABLE_ENTRIES-1:0] valid_vec;
	logic                     send_clear;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q   <= '0;
			iface_up_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_OWN_IP) begin
				own_ip_q <= cfg_wdata[IP_W-1:0];
			end
			if (cfg_index == CFG_IFACE_UP) begin
				iface_up_q <= cfg_wdata[0];
			end
		end
	end

	arpc_front u_front (
		.action        (action),
		.header_length (header_length),
		.opcode        (opcode),
		.protocol      (protocol),
		.hw_len        (hw_len),
		.proto_len     (proto_len),
		.sender_mac    (sender_mac),
		.sender_ip     (sender_ip),
		.query_ip      (query_ip),
		.own_ip        (own_ip_q),
		.iface_up      (iface_up_q),
		.cmd           (front_cmd)
	);

	arpc_cmd_fifo u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (full),
		.pop      (q_take),
		.pop_cmd  (q_cmd),
		.empty    (q_empty)
	);

	arpc_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_empty),
		.cmd       (q_cmd),
		.cmd_take  (q_take),
		.res       (res),
		.res_valid (res_valid),
		.res_pop   (pop),
		.valid_vec (valid_vec)
	);

	assign empty           = !res_valid;
	assign status          = res.status;
	assign found_mac       = res.found_mac;
	assign send            = res.send;
	assign send_opcode     = res.send_opcode;
	assign send_dest_mac   = res.send_dest_mac;
	assign send_target_mac = res.send_target_mac;
	assign send_target_ip  = res.send_target_ip;

	assign send_clear = (send_opcode == SEND_OP_NONE) && (send_dest_mac == '0) &&
		(send_target_mac == '0) && (send_target_ip == '0);

	// entries are never dropped once learned
	`ARPC_ASSERT_ALWAYS(a_valid_sticky, clk, arst_n, (~valid_vec & $past(valid_vec)) == '0)
	// at most one new entry per cycle
	`ARPC_ASSERT_ALWAYS(a_one_fill, clk, arst_n, $countones(valid_vec ^ $past(valid_vec)) <= 1)
	// a miss carries no MAC
	`ARPC_ASSERT_IMPL(a_miss_no_mac, clk, arst_n, !empty && status == ST_MISS, found_mac == '0)
	// no frame means all send fields are clear
	`ARPC_ASSERT_IMPL(a_idle_send, clk, arst_n, !empty && !send, send_clear)

endmodule

/* bench/arp_cache_responder_tb.sv */
// Self-checking testbench for the ARP cache and responder.
`timescale 1ns / 1ps

module arp_cache_responder_tb;
	import arpc_pkg::*;

	// Bench sizing and pacing.
	localparam int TABLE_ENTRIES   = ARPC_TABLE_ENTRIES;
	localparam int POOL_SIZE       = 24;	// more addresses than entries, so the table fills
	localparam int DIR_ROWS        = 21;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int IDLE_PCT        = 24;
	localparam int HOLD_CYCLES     = 80;	// long receiver hold-off that fills the block
	localparam int DRAIN_CYCLES    = 24;	// idle clocks run after the last result
	localparam int LIMIT_CYCLES    = 200000;

	// Codes the package does not name.
	localparam logic [1:0]  ACT_UNUSED   = 2'd3;
	localparam logic [15:0] ARP_OP_REPLY = 16'd2;
	localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;

	// Fixed addresses for the directed rows.
	localparam logic [IP_W-1:0]  IP_A  = 32'hC0A8_0A01;
	localparam logic [IP_W-1:0]  IP_B  = 32'hC0A8_0A02;
	localparam logic [IP_W-1:0]  IP_D  = 32'h0A00_0001;
	localparam logic [MAC_W-1:0] MAC_A = 48'h02_11_22_33_44_55;
	localparam logic [MAC_W-1:0] MAC_B = 48'h02_66_77_88_99_AA;
	localparam logic [MAC_W-1:0] MAC_C = 48'h02_DE_AD_00_BE_EF;

	// One input item, in port order.
	typedef struct packed {
		logic [1:0]       action;
		logic [10:0]      hlen;
		logic [15:0]      opcode;
		logic [15:0]      protocol;
		logic [7:0]       hw_len;
		logic [7:0]       proto_len;
		logic [MAC_W-1:0] smac;
		logic [IP_W-1:0]  sip;
		logic [IP_W-1:0]  tip;
	} arp_item_t;

	// Directed row: the item, plus a hand-written result where one is given.
	typedef struct {
		arp_item_t item;
		bit        typed;
		res_t      want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	logic                  full;
	logic [1:0]            action;
	logic [10:0]           header_length;
	logic [15:0]           opcode;
	logic [15:0]           protocol;
	logic [7:0]            hw_len;
	logic [7:0]            proto_len;
	logic [MAC_W-1:0]      sender_mac;
	logic [IP_W-1:0]       sender_ip;
	logic [IP_W-1:0]       query_ip;
	logic                  empty;
	logic                  pop;
	logic [2:0]            status;
	logic [MAC_W-1:0]      found_mac;
	logic                  send;
	logic [1:0]            send_opcode;
	logic [MAC_W-1:0]      send_dest_mac;
	logic [MAC_W-1:0]      send_target_mac;
	logic [IP_W-1:0]       send_target_ip;

	arp_cache_responder dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.push            (push),
		.full            (full),
		.action          (action),
		.header_length   (header_length),
		.opcode          (opcode),
		.protocol        (protocol),
		.hw_len          (hw_len),
		.proto_len       (proto_len),
		.sender_mac      (sender_mac),
		.sender_ip       (sender_ip),
		.query_ip        (query_ip),
		.empty           (empty),
		.pop             (pop),
		.status          (status),
		.found_mac       (found_mac),
		.send            (send),
		.send_opcode     (send_opcode),
		.send_dest_mac   (send_dest_mac),
		.send_target_mac (send_target_mac),
		.send_target_ip  (send_target_ip)
	);

	// Bench copy of the registers and the ARP table.
	logic [IP_W-1:0]  cfg_own_ip;
	logic [MAC_W-1:0] cfg_own_mac;
	logic             cfg_iface_up;
	logic             tbl_valid [TABLE_ENTRIES];
	logic [IP_W-1:0]  tbl_ip    [TABLE_ENTRIES];
	logic [MAC_W-1:0] tbl_mac   [TABLE_ENTRIES];

	// Results still owed by the block, oldest first.
	res_t pending_arp_results[$];
	res_t head_res;

	logic [IP_W-1:0] ip_pool [POOL_SIZE];
	dir_row_t        dir_rows [DIR_ROWS];

	// Run control shared with the receiver: stretch with no idling, hold-off requests.
	logic no_idle;
	int   stall_req;
	int   stall_seen;
	int   hold_left;

	int cycle_count;
	int mismatches;
	int items_sent;
	int results_seen;
	int full_waits;
	int lookup_hits;
	int replies_due;
	int requests_due;
	int learns_dropped;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// One line per mismatch, and a count.
	task automatic log_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
			results_seen, what, got, want);
		mismatches++;
	endtask

	function automatic int find_ip(input logic [IP_W-1:0] ip);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (tbl_valid[i] && tbl_ip[i] == ip)
				return i;
		return -1;
	endfunction

	// Expected result of one item; a valid header also updates the bench table.
	function automatic res_t compute_arp_result(input arp_item_t it);
		res_t r;
		int   hit;
		int   slot;
		r = '0;
		case (it.action)
			ACT_LOOKUP: begin
				hit = find_ip(it.tip);
				if (hit >= 0) begin
					r.found_mac = tbl_mac[hit];
					lookup_hits++;
				end else
					r.status = ST_MISS;
			end
			ACT_HEADER: begin
				if (it.hlen < MIN_HEADER_LEN)
					r.status = ST_SHORT;
				else if (it.protocol != PROTO_IPV4 || it.hw_len != HW_LEN_MAC ||
						it.proto_len != PROTO_LEN_IP)
					r.status = ST_UNSUPPORTED;
				else begin
					// learn: overwrite a known IP, else lowest free slot, else drop
					hit = find_ip(it.sip);
					if (hit >= 0)
						tbl_mac[hit] = it.smac;
					else begin
						slot = -1;
						for (int i = 0; i < TABLE_ENTRIES; i++)
							if (!tbl_valid[i] && slot < 0)
								slot = i;
						if (slot >= 0) begin
							tbl_valid[slot] = 1'b1;
							tbl_ip[slot]    = it.sip;
							tbl_mac[slot]   = it.smac;
						end else
							learns_dropped++;
					end
					// a request for our address is answered even while down
					if (it.opcode == ARP_OP_REQUEST && it.tip == cfg_own_ip) begin
						r.send            = 1'b1;
						r.send_opcode     = SEND_OP_REPLY;
						r.send_dest_mac   = it.smac;
						r.send_target_mac = it.smac;
						r.send_target_ip  = it.sip;
						replies_due++;
					end
				end
			end
			ACT_SEND: begin
				if (!cfg_iface_up)
					r.status = ST_DOWN;
				else begin
					r.send           = 1'b1;
					r.send_opcode    = SEND_OP_REQUEST;
					r.send_dest_mac  = MAC_BCAST;
					r.send_target_ip = it.tip;
					requests_due++;
				end
			end
			default: begin
				r.status = ST_UNSUPPORTED;
			end
		endcase
		return r;
	endfunction

	function automatic arp_item_t mk_item(input logic [1:0] act, input logic [10:0] hlen,
			input logic [15:0] op, input logic [15:0] proto, input logic [7:0] hw,
			input logic [7:0] pl, input logic [MAC_W-1:0] smac,
			input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
		arp_item_t it;
		it = '{act, hlen, op, proto, hw, pl, smac, sip, tip};
		return it;
	endfunction

	function automatic res_t mk_res(input logic [2:0] st, input logic [MAC_W-1:0] found,
			input logic snd, input logic [1:0] sop, input logic [MAC_W-1:0] dmac,
			input logic [MAC_W-1:0] tmac, input logic [IP_W-1:0] tpa);
		res_t r;
		r = '{st, found, snd, sop, dmac, tmac, tpa};
		return r;
	endfunction

	// Random item: mostly well-formed headers and lookups on pooled addresses,
	// with noise fields everywhere else so every input bit moves.
	function automatic arp_item_t random_item();
		arp_item_t it;
		int        pick;
		int        shape;
		it.action    = 2'($urandom);
		it.hlen      = 11'($urandom);
		it.opcode    = 16'($urandom);
		it.protocol  = 16'($urandom);
		it.hw_len    = 8'($urandom);
		it.proto_len = 8'($urandom);
		it.smac      = {16'($urandom), $urandom};
		it.sip       = $urandom;
		it.tip       = $urandom;
		pick = $urandom_range(99);
		if (pick < 35) begin
			it.action = ACT_LOOKUP;
			if ($urandom_range(9) < 8)
				it.tip = ip_pool[$urandom_range(POOL_SIZE - 1)];
		end else if (pick < 75) begin
			it.action = ACT_HEADER;
			if ($urandom_range(9) < 9)
				it.sip = ip_pool[$urandom_range(POOL_SIZE - 1)];
			shape = $urandom_range(9);
			// shape 0 leaves the header as noise
			if (shape != 0) begin
				it.hlen      = 11'($urandom_range(2047, int'(MIN_HEADER_LEN)));
				it.protocol  = PROTO_IPV4;
				it.hw_len    = HW_LEN_MAC;
				it.proto_len = PROTO_LEN_IP;
				case ($urandom_range(3))
					0, 1: it.opcode = ARP_OP_REQUEST;
					2: it.opcode = ARP_OP_REPLY;
					default: ;
				endcase
				if ($urandom_range(1) == 0)
					it.tip = cfg_own_ip;
				else if ($urandom_range(1) == 0)
					it.tip = ip_pool[$urandom_range(POOL_SIZE - 1)];
				// shapes 1 and 2 break exactly one check
				if (shape < 3) begin
					case ($urandom_range(3))
						0: it.hlen = 11'($urandom_range(int'(MIN_HEADER_LEN) - 1, 0));
						1: it.protocol = PROTO_IPV4 ^ 16'($urandom_range(65535, 1));
						2: it.hw_len = HW_LEN_MAC ^ 8'($urandom_range(255, 1));
						default: it.proto_len = PROTO_LEN_IP ^ 8'($urandom_range(255, 1));
					endcase
				end
			end
		end else if (pick < 95) begin
			it.action = ACT_SEND;
			if ($urandom_range(1) == 0)
				it.tip = ip_pool[$urandom_range(POOL_SIZE - 1)];
		end else
			it.action = ACT_UNUSED;
		return it;
	endfunction

	// Register write; the block takes it at the next edge, no wait state.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_OWN_IP:  cfg_own_ip = val[IP_W-1:0];
			CFG_OWN_MAC: cfg_own_mac = val[MAC_W-1:0];
			default:     cfg_iface_up = val[0];
		endcase
		@(posedge clk);
	endtask

	// Offer one item and wait for it to be taken; push stays high into the
	// next item unless an idle gap is drawn.
	task automatic offer_item(input arp_item_t it, input bit typed, input res_t want);
		res_t pred;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push          <= 1'b1;
		action        <= it.action;
		header_length <= it.hlen;
		opcode        <= it.opcode;
		protocol      <= it.protocol;
		hw_len        <= it.hw_len;
		proto_len     <= it.proto_len;
		sender_mac    <= it.smac;
		sender_ip     <= it.sip;
		query_ip      <= it.tip;
		@(posedge clk);
		while (full) begin
			full_waits++;
			@(posedge clk);
		end
		pred = compute_arp_result(it);
		pending_arp_results.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Receiver: check every accepted result against the oldest expectation,
	// then decide pop for the next edge.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_arp_results.size() == 0)
				log_mismatch("arrived with nothing pending, status", 64'(status), '0);
			else begin
				head_res = pending_arp_results.pop_front();
				if (status !== head_res.status)
					log_mismatch("status", 64'(status), 64'(head_res.status));
				if (found_mac !== head_res.found_mac)
					log_mismatch("found_mac", 64'(found_mac), 64'(head_res.found_mac));
				if (send !== head_res.send)
					log_mismatch("send", 64'(send), 64'(head_res.send));
				if (send_opcode !== head_res.send_opcode)
					log_mismatch("send_opcode", 64'(send_opcode),
						64'(head_res.send_opcode));
				if (send_dest_mac !== head_res.send_dest_mac)
					log_mismatch("send_dest_mac", 64'(send_dest_mac),
						64'(head_res.send_dest_mac));
				if (send_target_mac !== head_res.send_target_mac)
					log_mismatch("send_target_mac", 64'(send_target_mac),
						64'(head_res.send_target_mac));
				if (send_target_ip !== head_res.send_target_ip)
					log_mismatch("send_target_ip", 64'(send_target_ip),
						64'(head_res.send_target_ip));
			end
			results_seen++;
		end
		if (hold_left > 0) begin
			pop <= 1'b0;
			hold_left--;
		end else if (stall_req != stall_seen) begin
			// hold-off asked by the sender side
			stall_seen = stall_req;
			hold_left  = HOLD_CYCLES;
			pop <= 1'b0;
		end else
			pop <= no_idle || $urandom_range(99) >= IDLE_PCT;
	end

	// Timeout.
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("timeout after %0d cycles, %0d results still pending",
			cycle_count, pending_arp_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

	// Main sequence: reset, directed rows, then random phases under new settings.
	initial begin
		logic [IP_W-1:0]  ph_ip;
		logic [MAC_W-1:0] ph_mac;
		logic             ph_up;
		clk           = 1'b0;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		push          = 1'b0;
		pop           = 1'b0;
		action        = '0;
		header_length = '0;
		opcode        = '0;
		protocol      = '0;
		hw_len        = '0;
		proto_len     = '0;
		sender_mac    = '0;
		sender_ip     = '0;
		query_ip      = '0;
		no_idle       = 1'b0;
		stall_req     = 0;
		stall_seen    = 0;
		hold_left     = 0;
		cycle_count   = 0;
		mismatches    = 0;
		items_sent    = 0;
		results_seen  = 0;
		full_waits    = 0;
		lookup_hits   = 0;
		replies_due   = 0;
		requests_due  = 0;
		learns_dropped = 0;

		// registers and table come out of reset as zero
		cfg_own_ip   = '0;
		cfg_own_mac  = '0;
		cfg_iface_up = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_ip[i]    = '0;
			tbl_mac[i]   = '0;
		end

		ip_pool[0] = '0;
		ip_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;

		// Directed rows, run with the reset settings: own IP 0, interface down.
		// Lookups on an empty table miss.
		dir_rows[0] = '{mk_item(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
			mk_res(ST_MISS, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[1] = '{mk_item(ACT_LOOKUP, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1,
			mk_res(ST_MISS, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// send request while down
		dir_rows[2] = '{mk_item(ACT_SEND, '1, '1, '1, '1, '1, '1, '1, IP_A), 1'b1,
			mk_res(ST_DOWN, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// unused action
		dir_rows[3] = '{mk_item(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1, '1), 1'b1,
			mk_res(ST_UNSUPPORTED, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// short headers, otherwise a request for our address
		dir_rows[4] = '{mk_item(ACT_HEADER, 11'd0, ARP_OP_REQUEST, PROTO_IPV4, HW_LEN_MAC,
			PROTO_LEN_IP, MAC_A, IP_D, '0), 1'b1,
			mk_res(ST_SHORT, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[5] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN - 11'd1, ARP_OP_REQUEST,
			PROTO_IPV4, HW_LEN_MAC, PROTO_LEN_IP, MAC_A, IP_D, '0), 1'b1,
			mk_res(ST_SHORT, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// one bad field each
		dir_rows[6] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN, ARP_OP_REQUEST, ETH_TYPE_ARP,
			HW_LEN_MAC, PROTO_LEN_IP, MAC_A, IP_D, '0), 1'b1,
			mk_res(ST_UNSUPPORTED, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[7] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN, ARP_OP_REQUEST, PROTO_IPV4,
			8'd5, PROTO_LEN_IP, MAC_A, IP_D, '0), 1'b1,
			mk_res(ST_UNSUPPORTED, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[8] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN, ARP_OP_REQUEST, PROTO_IPV4,
			HW_LEN_MAC, 8'd16, MAC_A, IP_D, '0), 1'b1,
			mk_res(ST_UNSUPPORTED, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// rejected headers taught nothing
		dir_rows[9] = '{mk_item(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0, IP_D), 1'b1,
			mk_res(ST_MISS, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// learn from a reply aimed elsewhere, then hit it
		dir_rows[10] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN, ARP_OP_REPLY, PROTO_IPV4,
			HW_LEN_MAC, PROTO_LEN_IP, MAC_A, IP_A, IP_B), 1'b1,
			mk_res(ST_OK, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[11] = '{mk_item(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0, IP_A), 1'b1,
			mk_res(ST_OK, MAC_A, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// request for our address is answered although the interface is down
		dir_rows[12] = '{mk_item(ACT_HEADER, '1, ARP_OP_REQUEST, PROTO_IPV4, HW_LEN_MAC,
			PROTO_LEN_IP, MAC_B, IP_B, '0), 1'b1,
			mk_res(ST_OK, '0, 1'b1, SEND_OP_REPLY, MAC_B, MAC_B, IP_B)};
		// odd opcode still learns: overwrite of a known IP, no reply
		dir_rows[13] = '{mk_item(ACT_HEADER, 11'd100, '1, PROTO_IPV4, HW_LEN_MAC,
			PROTO_LEN_IP, MAC_C, IP_A, '0), 1'b1,
			mk_res(ST_OK, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[14] = '{mk_item(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0, IP_A), 1'b1,
			mk_res(ST_OK, MAC_C, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// all-zero sender: reply with zero fields, and a hit that returns MAC 0
		dir_rows[15] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN, ARP_OP_REQUEST, PROTO_IPV4,
			HW_LEN_MAC, PROTO_LEN_IP, '0, '0, '0), 1'b1,
			mk_res(ST_OK, '0, 1'b1, SEND_OP_REPLY, '0, '0, '0)};
		dir_rows[16] = '{mk_item(ACT_LOOKUP, '1, '1, '1, '1, '1, '1, '1, '0), 1'b1,
			mk_res(ST_OK, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// all-ones sender, request for someone else
		dir_rows[17] = '{mk_item(ACT_HEADER, MIN_HEADER_LEN, ARP_OP_REQUEST, PROTO_IPV4,
			HW_LEN_MAC, PROTO_LEN_IP, '1, '1, IP_A), 1'b1,
			mk_res(ST_OK, '0, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		dir_rows[18] = '{mk_item(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0, '1), 1'b1,
			mk_res(ST_OK, '1, 1'b0, SEND_OP_NONE, '0, '0, '0)};
		// left to the predictor
		dir_rows[19] = '{mk_item(ACT_HEADER, 11'd60, '0, PROTO_IPV4, HW_LEN_MAC,
			PROTO_LEN_IP, MAC_A, IP_D, IP_B), 1'b0, '0};
		dir_rows[20] = '{mk_item(ACT_LOOKUP, '0, '0, '0, '0, '0, '0, '0, IP_B), 1'b0, '0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < DIR_ROWS; r++)
			offer_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

		for (int p = 0; p < PHASES; p++) begin
			// settle: every owed result back before touching the registers
			push <= 1'b0;
			while (pending_arp_results.size() != 0)
				@(posedge clk);

			ph_ip  = (p == 1) ? '0 : (p == 2) ? '1 : ip_pool[$urandom_range(POOL_SIZE - 1)];
			ph_mac = (p == 0) ? '1 : (p == 1) ? '0 : {16'($urandom), $urandom};
			ph_up  = !(p == 1 || p == 5);
			// junk in the unused upper bits must be ignored
			write_reg(CFG_OWN_IP, {16'($urandom), ph_ip});
			write_reg(CFG_OWN_MAC, ph_mac);
			write_reg(CFG_IFACE_UP, {47'({$urandom, $urandom}), ph_up});

			no_idle <= (p == 2);
			if (p == 4)
				stall_req <= stall_req + 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				offer_item(random_item(), 1'b0, '0);
		end

		push <= 1'b0;
		while (pending_arp_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d items over %0d register settings: %0d lookup hits, %0d replies,",
			items_sent, PHASES + 1, lookup_hits, replies_due);
		$display("%0d broadcast requests, %0d learns dropped on a full table, %s %0d",
			requests_due, learns_dropped, "cycles held by full:", full_waits);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/arpc_pkg.sv
rtl/arpc_ram.sv
rtl/arpc_front.sv
rtl/arpc_cmd_fifo.sv
rtl/arpc_back.sv
rtl/arp_cache_responder.sv
bench/arp_cache_responder_tb.sv
